>>> rtl/core/pfx_pkg.sv
// ----------------------------------------------------------------------------
// pfx_pkg
// Shared types, sizes and codes of the postfix stack evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfx_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int DEPTH_W     = 5;
    localparam int STATUS_W    = 2;
    localparam int CODE_W      = 3;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    localparam logic KIND_OPERAND  = 1'b0;
    localparam logic KIND_OPERATOR = 1'b1;

    localparam logic [CODE_W-1:0] OP_ADD = 3'd0;
    localparam logic [CODE_W-1:0] OP_SUB = 3'd1;
    localparam logic [CODE_W-1:0] OP_MUL = 3'd2;
    localparam logic [CODE_W-1:0] OP_DIV = 3'd3;
    localparam logic [CODE_W-1:0] OP_MOD = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZERO   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] operand_value;
        logic [CODE_W-1:0]        operator_code;
        logic                     first_token;
    } t_token;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [DEPTH_W-1:0]       depth;
        logic [STATUS_W-1:0]      status;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic                latch;
        logic                push;
        logic                rd;
        logic                div_start;
        logic                wr_res;
        logic                load_out;
        logic [STATUS_W-1:0] status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_operand;
        logic full;
        logic underflow;
        logic divzero;
        logic is_divop;
        logic div_done;
    } t_stat;

endpackage

`default_nettype wire

>>> rtl/core/pfx_tok_if.sv
// ----------------------------------------------------------------------------
// pfx_tok_if
// Token channel: valid, ready and one token.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfx_tok_if import pfx_pkg::*; ;
    logic   valid;
    logic   ready;
    t_token data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/pfx_res_if.sv
// ----------------------------------------------------------------------------
// pfx_res_if
// Result channel: valid, ready and one result.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfx_res_if import pfx_pkg::*; ;
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/pfx_div.sv
// ----------------------------------------------------------------------------
// pfx_div
// Iterative signed divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`default_nettype none

module pfx_div import pfx_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [DATA_W-1:0] i_dividend,
    input  wire logic signed [DATA_W-1:0] i_divisor,
    output logic                          o_done,
    output logic signed [DATA_W-1:0]      o_quot,
    output logic signed [DATA_W-1:0]      o_rem
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_quo;
    logic [DATA_W-1:0]    r_dvs;
    logic                 r_neg_q;
    logic                 r_neg_r;

    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   diff;

    // magnitudes as unsigned; most negative value maps to 2^31
    assign mag_a  = i_dividend[DATA_W-1] ? -i_dividend : i_dividend;
    assign mag_b  = i_divisor[DATA_W-1]  ? -i_divisor  : i_divisor;
    assign rem_sh = {r_rem, r_quo[DATA_W-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= '0;
            r_quo   <= mag_a;
            r_dvs   <= mag_b;
            r_neg_q <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
            r_neg_r <= i_dividend[DATA_W-1];
        end else if (r_busy) begin
            r_rem <= diff[DATA_W] ? rem_sh[DATA_W-1:0] : diff[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], ~diff[DATA_W]};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg_q ? -r_quo : r_quo;
    assign o_rem  = r_neg_r ? -r_rem : r_rem;

endmodule

`default_nettype wire

>>> rtl/core/pfx_dpath.sv
// ----------------------------------------------------------------------------
// pfx_dpath
// Stack memory, cached top, entry count, ALU, divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfx_dpath import pfx_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_token i_tok,
    input  wire t_cmd   i_cmd,
    output t_stat       o_stat,
    output t_result     o_res
);

    localparam int EXT_W = CNT_W + DEPTH_W;

    logic signed [DATA_W-1:0] mem [STACK_DEPTH];

    t_token                   r_tok;
    logic [CNT_W-1:0]         r_count;
    logic signed [DATA_W-1:0] r_top;
    logic signed [DATA_W-1:0] r_rd;
    t_result                  r_out;

    logic [CNT_W-1:0]         cnt_m2;
    logic [ADDR_W-1:0]        addr_a;
    logic [ADDR_W-1:0]        waddr;
    logic signed [DATA_W-1:0] wdata;
    logic signed [DATA_W-1:0] alu;
    logic signed [DATA_W-1:0] res;
    logic                     is_divop;
    logic                     div_done;
    logic signed [DATA_W-1:0] quot;
    logic signed [DATA_W-1:0] rem;
    logic [EXT_W-1:0]         cnt_ext;

    assign cnt_m2   = r_count - CNT_W'(2);
    assign addr_a   = cnt_m2[ADDR_W-1:0];
    assign is_divop = (r_tok.operator_code == OP_DIV) || (r_tok.operator_code == OP_MOD);

    // b is the cached top, a comes from the registered memory read
    always_comb begin
        case (r_tok.operator_code)
            OP_ADD:  alu = r_rd + r_top;
            OP_SUB:  alu = r_rd - r_top;
            OP_MUL:  alu = r_rd * r_top;
            default: alu = '0;
        endcase
    end

    always_comb begin
        if (is_divop) begin
            res = (r_tok.operator_code == OP_DIV) ? quot : rem;
        end else begin
            res = alu;
        end
    end

    assign waddr = i_cmd.push ? r_count[ADDR_W-1:0] : addr_a;
    assign wdata = i_cmd.push ? r_tok.operand_value : res;

    pfx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rd),
        .i_divisor  (r_top),
        .o_done     (div_done),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.push || i_cmd.wr_res) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.rd) begin
            r_rd <= mem[addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.latch) begin
            r_count <= i_tok.first_token ? '0 : r_count;
        end else if (i_cmd.push) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.wr_res) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    assign cnt_ext = EXT_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_tok <= i_tok;
        end
        if (i_cmd.push || i_cmd.wr_res) begin
            r_top <= wdata;
        end
        if (i_cmd.load_out) begin
            r_out.top_value <= (r_count != '0) ? r_top : '0;
            r_out.depth     <= cnt_ext[DEPTH_W-1:0];
            r_out.status    <= i_cmd.status;
        end
    end

    always_comb begin
        o_stat.is_operand = (r_tok.kind == KIND_OPERAND);
        o_stat.full       = (r_count >= CNT_W'(STACK_DEPTH));
        o_stat.underflow  = (r_count < CNT_W'(2));
        o_stat.divzero    = is_divop && (r_top == '0);
        o_stat.is_divop   = is_divop;
        o_stat.div_done   = div_done;
    end

    assign o_res = r_out;

endmodule

`default_nettype wire

>>> rtl/core/pfx_ctrl.sv
// ----------------------------------------------------------------------------
// pfx_ctrl
// Token sequencer: decode, operand fetch, divide wait, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module pfx_ctrl import pfx_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_tok_valid,
    output logic       o_tok_ready,
    output logic       o_res_valid,
    input  wire logic  i_res_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_DIVIDE,
        S_DONE
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    logic                out_free;

    assign out_free = !r_out_valid || i_res_ready;

    always_comb begin
        n_state         = r_state;
        n_status        = r_status;
        o_cmd           = '0;
        o_cmd.status    = r_status;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.latch = i_tok_valid;
                if (i_tok_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state  = S_DONE;
                n_status = ST_OK;
                if (i_stat.is_operand) begin
                    if (i_stat.full) begin
                        n_status = ST_FULL;
                    end else begin
                        o_cmd.push = 1'b1;
                    end
                end else if (i_stat.underflow) begin
                    n_status = ST_UNDERFLOW;
                end else if (i_stat.divzero) begin
                    n_status = ST_DIVZERO;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_FETCH;
                end
            end
            S_FETCH: begin
                if (i_stat.is_divop) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIVIDE;
                end else begin
                    o_cmd.wr_res = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_DIVIDE: begin
                if (i_stat.div_done) begin
                    o_cmd.wr_res = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                // hold here while the previous result is still unclaimed
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_status    <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_tok_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;

endmodule

`default_nettype wire

>>> rtl/core/postfix_stack_evaluator_top.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_top
// Postfix integer expression evaluator on a bounded value stack.
// ----------------------------------------------------------------------------
// Channel   Dir  Modport  Payload
// i_tok     in   sink     kind, operand_value, operator_code, first_token
// o_res     out  source   top_value, depth, status
//
// Per token: decode; push or rejected token then done; add/sub/mul add a fetch
// (registered stack read of the lower operand); div/mod add the fetch and a
// divide wait (32 divider iterations); the result register loads in S_DONE.
// Synchronous active-low reset empties the stack; memory is not cleared.
// A new token is taken while a result waits; the next result then holds in
// the last step until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_stack_evaluator_top import pfx_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pfx_tok_if.sink    i_tok,
    pfx_res_if.source  o_res
);

    t_cmd  cmd;
    t_stat stat;

    pfx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (i_tok.valid),
        .o_tok_ready (i_tok.ready),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pfx_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (i_tok.data),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_res   (o_res.data)
    );

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tok.valid && i_tok.ready) |=> !i_tok.ready)
        else $error("token taken while previous one in flight");

    a_full_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.data.status == ST_FULL)) |->
        (o_res.data.depth == DEPTH_W'(STACK_DEPTH)))
        else $error("stack full reported below capacity");

    a_under_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.data.status == ST_UNDERFLOW)) |->
        (o_res.data.depth < DEPTH_W'(2)))
        else $error("underflow reported with two or more entries");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.data.depth == '0)) |->
        (o_res.data.top_value == '0))
        else $error("empty stack shows nonzero top");

endmodule

`default_nettype wire
